/* design/double_ended_queue_with_search_unit_macros.svh */
// assertion macros for the deque with search unit
// used by the top level only, no other dependencies
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DQS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dqs same-cycle check failed");

// next-cycle implication, checked outside reset
`define DQS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dqs next-cycle check failed");

`endif

/* design/dqs_pkg.sv */
// shared types and constants for the deque with search unit
// no dependencies
`timescale 1ns / 1ps

package dqs_pkg;

  localparam int OP_W     = 3;
  localparam int TICKET_W = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_LIST_FWD   = 3'd4,
    OP_LIST_BACK  = 3'd5,
    OP_SEARCH     = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SRC_CODE,
    SRC_POP,
    SRC_WALK
  } res_src_t;

  typedef struct packed {
    logic     capture;
    logic     push_front;
    logic     push_rear;
    logic     rd_en;
    logic     pop_commit;
    logic     step;
    logic     load;
    res_src_t src;
    status_t  code;
    logic     final_flag;
  } dqs_cmd_t;

  typedef struct packed {
    logic is_empty;
    logic is_full;
    logic hit;
    logic walk_end;
    logic last;
    op_t  op;
  } dqs_stat_t;

  typedef struct packed {
    status_t                    status;
    logic signed [TICKET_W-1:0] value;
    logic [POS_W-1:0]           position;
    logic                       last;
  } dqs_result_t;

endpackage

/* design/dqs_ifs.sv */
// request and response channel interfaces for the deque with search unit
// depends on dqs_pkg
`timescale 1ns / 1ps

interface dqs_in_if import dqs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic signed [TICKET_W-1:0] ticket;

  modport source (output valid, output operation, output ticket, input ready);
  modport sink (input valid, input operation, input ticket, output ready);
endinterface

interface dqs_out_if import dqs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [TICKET_W-1:0] value;
  logic [POS_W-1:0]           position;
  logic                       last;

  modport source (output valid, output status, output value, output position, output last,
                  input ready);
  modport sink (input valid, input status, input value, input position, input last,
                output ready);
endinterface

/* design/dqs_ctrl.sv */
// controller state machine for the deque with search unit
// depends on dqs_pkg; drives dqs_dp through command and status structs
`timescale 1ns / 1ps

module dqs_ctrl import dqs_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output dqs_cmd_t        cmd,
  input  dqs_stat_t       st
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd.capture    = 1'b0;
    cmd.push_front = 1'b0;
    cmd.push_rear  = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.pop_commit = 1'b0;
    cmd.step       = 1'b0;
    cmd.load       = 1'b0;
    cmd.src        = SRC_CODE;
    cmd.code       = ST_OK;
    cmd.final_flag = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              cmd.load   = 1'b1;
              state_next = S_EMIT;
              if (st.is_full) begin
                cmd.code = ST_FULL;
              end else begin
                cmd.push_front = (in_op == OP_PUSH_FRONT);
                cmd.push_rear  = (in_op == OP_PUSH_REAR);
              end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_LIST_FWD, OP_LIST_BACK, OP_SEARCH: begin
              if (st.is_empty) begin
                cmd.load   = 1'b1;
                cmd.code   = ST_EMPTY;
                state_next = S_EMIT;
              end else begin
                cmd.capture = 1'b1;
                state_next  = S_FETCH;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_FETCH: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        unique case (st.op)
          OP_POP_FRONT, OP_POP_REAR: begin
            cmd.pop_commit = 1'b1;
            cmd.load       = 1'b1;
            cmd.src        = SRC_POP;
            state_next     = S_EMIT;
          end
          OP_LIST_FWD, OP_LIST_BACK: begin
            cmd.load       = 1'b1;
            cmd.src        = SRC_WALK;
            cmd.final_flag = st.walk_end;
            state_next     = S_EMIT;
          end
          OP_SEARCH: begin
            if (st.hit) begin
              cmd.load   = 1'b1;
              cmd.src    = SRC_WALK;
              state_next = S_EMIT;
            end else if (st.walk_end) begin
              cmd.load   = 1'b1;
              cmd.code   = ST_NOT_FOUND;
              state_next = S_EMIT;
            end else begin
              cmd.step   = 1'b1;
              state_next = S_FETCH;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (st.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_FETCH;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/dqs_dp.sv */
// datapath for the deque with search unit: ring store, pointers, walk index, result register
// depends on dqs_pkg; controlled by dqs_ctrl
`timescale 1ns / 1ps

module dqs_dp import dqs_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dqs_cmd_t                   cmd,
  input  logic [OP_W-1:0]            in_op,
  input  logic signed [TICKET_W-1:0] in_ticket,
  output dqs_stat_t                  st,
  output dqs_result_t                res
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [IW:0] DEPTH_W = (IW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  logic signed [TICKET_W-1:0] mem [DEPTH];

  logic [IW-1:0]              front;
  logic [CW-1:0]              count;
  op_t                        op_q;
  logic signed [TICKET_W-1:0] ticket_q;
  logic [IW-1:0]              idx;
  logic signed [TICKET_W-1:0] rd_data;

  logic [CW-1:0]  cnt_m1;
  logic           rev;
  logic [CW-1:0]  off_wide;
  logic [IW-1:0]  off;
  logic [PW-1:0]  pos_wide;
  logic [IW-1:0]  front_dec;
  logic [IW-1:0]  wr_addr;
  logic [IW-1:0]  rd_addr;
  logic           wr_en;

  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                             input logic [IW-1:0] ofs);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[IW-1:0];
  endfunction

  assign cnt_m1    = count - CW'(1);
  assign rev       = (op_q == OP_POP_REAR) || (op_q == OP_LIST_BACK);
  assign off_wide  = rev ? (cnt_m1 - CW'(idx)) : CW'(idx);
  assign off       = off_wide[IW-1:0];
  assign pos_wide  = PW'(off) + PW'(1);
  assign front_dec = (front == '0) ? LAST_IDX : (front - IW'(1));
  assign wr_addr   = cmd.push_front ? front_dec : ring_add(front, count[IW-1:0]);
  assign rd_addr   = ring_add(front, off);
  assign wr_en     = cmd.push_front || cmd.push_rear;

  // ring store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_ticket;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      if (cmd.push_front) begin
        front <= front_dec;
      end
      if (wr_en) begin
        count <= count + CW'(1);
      end
      if (cmd.pop_commit) begin
        count <= cnt_m1;
        if (op_q == OP_POP_FRONT) begin
          front <= ring_add(front, IW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= op_t'(in_op);
      ticket_q <= in_ticket;
      idx      <= '0;
    end else if (cmd.step) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (cmd.src)
        SRC_POP: begin
          res.status   <= ST_OK;
          res.value    <= rd_data;
          res.position <= '0;
          res.last     <= 1'b1;
        end
        SRC_WALK: begin
          res.status   <= ST_OK;
          res.value    <= rd_data;
          res.position <= pos_wide[POS_W-1:0];
          res.last     <= cmd.final_flag;
        end
        default: begin
          res.status   <= cmd.code;
          res.value    <= '0;
          res.position <= '0;
          res.last     <= 1'b1;
        end
      endcase
    end
  end

  assign st.is_empty = (count == '0);
  assign st.is_full  = (count == CW'(DEPTH));
  assign st.hit      = (rd_data == ticket_q);
  assign st.walk_end = (CW'(idx) == cnt_m1);
  assign st.last     = res.last;
  assign st.op       = op_q;

endmodule

/* design/double_ended_queue_with_search_unit.sv */
// top level of the deque with search unit: controller, datapath and checks
// depends on dqs_pkg, dqs_ifs, dqs_ctrl, dqs_dp and the assertion macro header
`timescale 1ns / 1ps
`include "double_ended_queue_with_search_unit_macros.svh"

// Bounded double-ended queue of signed 32-bit tickets held in a ring of DEPTH entries.
// req carries one operation per transaction: push front or rear, pop front or rear,
// list forward or backward, or search for a ticket. rsp returns results; last marks
// the final result of a request. Lists give one result per entry, everything else one.
// One request is handled at a time; req.ready is high only while the unit is idle.
// Push, full or empty reports: result valid in the cycle after the request transaction.
// Pop: the request passes through fetch and check, and the result is valid in emit.
// List: fetch, check and emit per entry: the store read, then the result register.
// Search: fetch and check for each entry examined, at most DEPTH, then emit.
// An undefined operation code is taken and dropped with no result.
// When rsp.ready is low the result register holds and the walk waits; no result is lost.
// Reset empties the queue at once; the store itself is not cleared and needs no pass.
module double_ended_queue_with_search_unit import dqs_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  dqs_in_if.sink    req,
  dqs_out_if.source rsp
);

  dqs_cmd_t    cmd;
  dqs_stat_t   st;
  dqs_result_t res;
  logic        req_accept;

  dqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_op     (req.operation),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .st        (st)
  );

  dqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_op     (req.operation),
    .in_ticket (req.ticket),
    .st        (st),
    .res       (res)
  );

  assign rsp.status   = res.status;
  assign rsp.value    = res.value;
  assign rsp.position = res.position;
  assign rsp.last     = res.last;

  assign req_accept = req.valid && req.ready;

  // no new request while a result is pending
  `DQS_ASSERT_IMPLY(a_no_overlap, clk, rst, req_accept, !rsp.valid)
  // error reports are always the only result of a request
  `DQS_ASSERT_IMPLY(a_err_last, clk, rst, rsp.valid && (rsp.status != ST_OK), rsp.last)
  // a push that fits leaves the queue non-empty
  `DQS_ASSERT_NEXT(a_push_fills, clk, rst,
    req_accept && !st.is_full &&
    ((req.operation == OP_PUSH_FRONT) || (req.operation == OP_PUSH_REAR)), !st.is_empty)

endmodule

/* tb/double_ended_queue_with_search_unit_tb.sv */
// testbench for the deque with search unit: directed corner cases, then random phases
// depends on dqs_pkg, dqs_ifs and the double_ended_queue_with_search_unit top level
`timescale 1ns / 1ps

module double_ended_queue_with_search_unit_tb import dqs_pkg::*; ();

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 480;
  localparam int TAIL_CYCLES = 4 * QUEUE_DEPTH + 16;
  localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;
  localparam logic signed [TICKET_W-1:0] TICKET_MIN = 32'sh8000_0000;
  localparam logic signed [TICKET_W-1:0] TICKET_MAX = 32'sh7fff_ffff;

  typedef enum int { PH_FILL, PH_DRAIN, PH_MIXED, PH_SCAN } phase_t;

  class ticket_deque_model;
    logic signed [TICKET_W-1:0] ring[QUEUE_DEPTH];
    int unsigned front_idx;
    int unsigned entry_cnt;
    dqs_result_t awaited[$];
    int unsigned mismatches;
    int unsigned requests_taken;
    int unsigned results_seen;
    int unsigned full_reports;
    int unsigned empty_reports;
    int unsigned miss_reports;

    function new();
      front_idx = 0;
      entry_cnt = 0;
      mismatches = 0;
      requests_taken = 0;
      results_seen = 0;
      full_reports = 0;
      empty_reports = 0;
      miss_reports = 0;
    endfunction

    function int unsigned slot(int unsigned offset);
      return (front_idx + offset) % QUEUE_DEPTH;
    endfunction

    function void queue_result(status_t st, logic signed [TICKET_W-1:0] v, int unsigned pos,
                               bit fin);
      dqs_result_t r;
      r.status = st;
      r.value = v;
      r.position = pos[POS_W-1:0];
      r.last = fin;
      awaited.push_back(r);
    endfunction

    function logic signed [TICKET_W-1:0] pick_present();
      if (entry_cnt == 0) return 0;
      return ring[slot($urandom_range(0, entry_cnt - 1))];
    endfunction

    // accepted request transaction
    function void note_request(logic [OP_W-1:0] op, logic signed [TICKET_W-1:0] ticket);
      int unsigned off;
      bit found;
      logic signed [TICKET_W-1:0] v;
      requests_taken++;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (entry_cnt >= QUEUE_DEPTH) begin
            queue_result(ST_FULL, 0, 0, 1'b1);
          end else begin
            if (op == OP_PUSH_FRONT) begin
              front_idx = (front_idx == 0) ? QUEUE_DEPTH - 1 : front_idx - 1;
              ring[front_idx] = ticket;
            end else begin
              ring[slot(entry_cnt)] = ticket;
            end
            entry_cnt++;
            queue_result(ST_OK, 0, 0, 1'b1);
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (entry_cnt == 0) begin
            queue_result(ST_EMPTY, 0, 0, 1'b1);
          end else begin
            if (op == OP_POP_FRONT) begin
              v = ring[front_idx];
              front_idx = slot(1);
            end else begin
              v = ring[slot(entry_cnt - 1)];
            end
            entry_cnt--;
            queue_result(ST_OK, v, 0, 1'b1);
          end
        end
        OP_LIST_FWD, OP_LIST_BACK: begin
          if (entry_cnt == 0) begin
            queue_result(ST_EMPTY, 0, 0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < entry_cnt; i++) begin
              off = (op == OP_LIST_FWD) ? i : entry_cnt - 1 - i;
              queue_result(ST_OK, ring[slot(off)], off + 1, i + 1 == entry_cnt);
            end
          end
        end
        OP_SEARCH: begin
          if (entry_cnt == 0) begin
            queue_result(ST_EMPTY, 0, 0, 1'b1);
          end else begin
            found = 1'b0;
            for (int unsigned i = 0; i < entry_cnt; i++) begin
              if (!found && ring[slot(i)] == ticket) begin
                queue_result(ST_OK, ticket, i + 1, 1'b1);
                found = 1'b1;
              end
            end
            if (!found) queue_result(ST_NOT_FOUND, 0, 0, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    // accepted response transaction
    function void check_result(dqs_result_t got);
      dqs_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result status=%0d value=%0d position=%0d last=%0b",
                 $time, got.status, got.value, got.position, got.last);
        return;
      end
      want = awaited.pop_front();
      case (want.status)
        ST_FULL: full_reports++;
        ST_EMPTY: empty_reports++;
        ST_NOT_FOUND: miss_reports++;
        default: ;
      endcase
      if (got.status !== want.status || got.value !== want.value ||
          got.position !== want.position || got.last !== want.last) begin
        mismatches++;
        $display("%0t: mismatch expected status=%0d value=%0d position=%0d last=%0b",
                 $time, want.status, want.value, want.position, want.last);
        $display("%0t:          actual   status=%0d value=%0d position=%0d last=%0b",
                 $time, got.status, got.value, got.position, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit tx_calm;
  bit rx_calm;
  ticket_deque_model deque_sb;

  dqs_in_if req_if();
  dqs_out_if rsp_if();

  double_ended_queue_with_search_unit #(.DEPTH(QUEUE_DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned idle_cycles(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic signed [TICKET_W-1:0] pick_ticket();
    case ($urandom_range(0, 9))
      0: return TICKET_MIN;
      1: return TICKET_MAX;
      2: return 0;
      3: return -1;
      4: return $urandom_range(1, 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(phase_t kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_UNDEFINED;
    case (kind)
      PH_FILL: return (r < 80) ? OP_W'($urandom_range(OP_PUSH_FRONT, OP_PUSH_REAR))
                               : OP_W'($urandom_range(OP_POP_FRONT, OP_SEARCH));
      PH_DRAIN: return (r < 70) ? OP_W'($urandom_range(OP_POP_FRONT, OP_POP_REAR))
                                : OP_W'($urandom_range(OP_PUSH_FRONT, OP_SEARCH));
      PH_SCAN: return (r < 50) ? OP_W'($urandom_range(OP_LIST_FWD, OP_SEARCH))
                               : OP_W'($urandom_range(OP_PUSH_FRONT, OP_POP_REAR));
      default: return OP_W'($urandom_range(OP_PUSH_FRONT, OP_SEARCH));
    endcase
  endfunction

  task automatic send_request(logic [OP_W-1:0] op, logic signed [TICKET_W-1:0] ticket);
    int unsigned gap;
    gap = idle_cycles(tx_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.ticket <= ticket;
    do @(posedge clk); while (!req_if.ready);
    deque_sb.note_request(op, ticket);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (deque_sb.awaited.size() != 0) @(posedge clk);
  endtask

  // response side: random stalls, checks each accepted transaction
  initial begin
    int unsigned stall_left;
    bit next_ready;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready)
        deque_sb.check_result('{status_t'(rsp_if.status), rsp_if.value, rsp_if.position,
                                rsp_if.last});
      if (rx_calm) begin
        next_ready = 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        next_ready = 1'b0;
        stall_left--;
      end else begin
        stall_left = idle_cycles(1'b0);
        next_ready = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
      rsp_if.ready <= next_ready;
    end
  end

  initial begin
    int unsigned counted;
    int unsigned phase_len;
    phase_t kind;
    logic [OP_W-1:0] op;
    logic signed [TICKET_W-1:0] ticket;
    deque_sb = new();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.operation <= OP_PUSH_FRONT;
    req_if.ticket <= 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty queue reports and an ignored code
    send_request(OP_POP_FRONT, 0);
    send_request(OP_POP_REAR, -1);
    send_request(OP_LIST_FWD, 0);
    send_request(OP_LIST_BACK, 0);
    send_request(OP_SEARCH, TICKET_MAX);
    send_request(OP_UNDEFINED, TICKET_MIN);
    // extreme tickets pushed at both ends, then lists, searches, pops and an ignored code
    send_request(OP_PUSH_FRONT, TICKET_MAX);
    send_request(OP_PUSH_REAR, TICKET_MIN);
    send_request(OP_PUSH_FRONT, 0);
    send_request(OP_PUSH_REAR, -1);
    send_request(OP_PUSH_REAR, TICKET_MAX);
    send_request(OP_LIST_FWD, 0);
    send_request(OP_LIST_BACK, 0);
    send_request(OP_SEARCH, TICKET_MIN);
    send_request(OP_SEARCH, TICKET_MAX);
    send_request(OP_SEARCH, 32'sd12345);
    send_request(OP_POP_FRONT, 0);
    send_request(OP_POP_REAR, 0);
    send_request(OP_UNDEFINED, TICKET_MAX);
    send_request(OP_LIST_FWD, 0);
    drain_results();

    counted = 0;
    kind = PH_FILL;
    while (counted < RANDOM_ITEMS) begin
      phase_len = $urandom_range(15, 50);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int unsigned k = 0; k < phase_len; k++) begin
        op = pick_op(kind);
        if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR)
          ticket = pick_ticket();
        else if (op == OP_SEARCH && $urandom_range(0, 1) == 1)
          ticket = deque_sb.pick_present();
        else if (op == OP_SEARCH)
          ticket = pick_ticket();
        else
          ticket = $urandom;
        send_request(op, ticket);
        if (op != OP_UNDEFINED) counted++;
      end
      if ($urandom_range(0, 2) == 0) drain_results();
      kind = phase_t'($urandom_range(PH_FILL, PH_SCAN));
    end

    drain_results();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results", deque_sb.requests_taken,
             deque_sb.results_seen);
    $display("full reports %0d, empty reports %0d, search misses %0d",
             deque_sb.full_reports, deque_sb.empty_reports, deque_sb.miss_reports);
    if (deque_sb.mismatches == 0 && deque_sb.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* double_ended_queue_with_search_unit.f */
+incdir+design
design/dqs_pkg.sv
design/dqs_ifs.sv
design/dqs_ctrl.sv
design/dqs_dp.sv
design/double_ended_queue_with_search_unit.sv
tb/double_ended_queue_with_search_unit_tb.sv
